// ----- hw/rtl/utf8lm_pkg.sv -----
// shared types, constants and a helper function for the utf8 latin-1 mojibake detector
// used by utf8lm_core and utf8_latin1_mojibake_detector

package utf8lm_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int CFG_WIDTH   = 16;
  localparam int CMP_WIDTH   = ((COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH) + 1;

  localparam logic [7:0] LEAD_C2 = 8'hC2;
  localparam logic [7:0] LEAD_C3 = 8'hC3;
  localparam logic [CFG_WIDTH-1:0] MIN_LATIN1_RESET = CFG_WIDTH'(3);

  typedef logic [COUNT_WIDTH-1:0] count_t;

  // one result item
  typedef struct packed {
    logic       extraction_ok;
    logic       legacy_pattern;
    logic       string_done;
    logic       byte_valid;
    logic [7:0] recovered_byte;
  } result_t;

  function automatic count_t sat_inc(input count_t v);
    sat_inc = (&v) ? v : v + count_t'(1);
  endfunction

endpackage

// ----- hw/rtl/utf8_latin1_mojibake_detector.sv -----
// top level of the utf8 latin-1 mojibake detector: input register, output register,
// handshake and configuration register; depends on utf8lm_pkg and utf8lm_core
//
// usage:
//   s_axis carries one byte of a utf-8 string per transaction in s_axis_tdata,
//   with s_axis_tlast on the final byte of the string.
//   m_axis returns exactly one transaction per input byte, in order:
//     m_axis_tdata[7:0] recovered byte, [8] legacy pattern, [9] extraction ok
//     m_axis_tuser      byte valid, m_axis_tlast string done.
//   legacy pattern and extraction ok are meaningful on the tlast transaction only,
//   after which the per-string counters and flags clear.
//   cfg_we / cfg_wdata write the minimum c2/c3 sequence count (reset value 3);
//   write it only while no byte is in flight.
// datapath: each input transaction passes the input register, then the result register
//   behind one pass of compare and saturating-count logic.
// throughput: one byte per cycle; both pipeline slots advance whenever the output
//   register is empty or being taken.
// reset: rst (synchronous) empties both slots, clears string state, restores config.
// stall: when m_axis_tready is low the result holds, the input register fills, and
//   s_axis_tready drops only once both slots are occupied.

module utf8_latin1_mojibake_detector (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [7:0]                           s_axis_tdata,  // in_byte
  input  logic                                 s_axis_tlast,  // is_last
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [15:0]                          m_axis_tdata,  // recovered_byte, legacy_pattern,
                                                              // extraction_ok, zero fill
  output logic                                 m_axis_tuser,  // byte_valid
  output logic                                 m_axis_tlast,  // string_done
  input  logic                                 cfg_we,
  input  logic [utf8lm_pkg::CFG_WIDTH-1:0]     cfg_wdata
);

  logic                              in_valid;
  logic [7:0]                        in_byte;
  logic                              in_last;
  logic                              out_valid;
  utf8lm_pkg::result_t               out_res;
  utf8lm_pkg::result_t               core_res;
  logic [utf8lm_pkg::CFG_WIDTH-1:0]  min_latin1_count;
  logic                              advance;
  logic                              s_accept;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  utf8lm_core u_core (
    .clk              (clk),
    .rst              (rst),
    .en               (advance),
    .in_byte          (in_byte),
    .is_last          (in_last),
    .min_latin1_count (min_latin1_count),
    .result           (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      min_latin1_count <= utf8lm_pkg::MIN_LATIN1_RESET;
    end else if (cfg_we) begin
      min_latin1_count <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_accept) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      in_byte <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= core_res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {6'b0, out_res.extraction_ok, out_res.legacy_pattern,
                          out_res.recovered_byte};
  assign m_axis_tuser  = out_res.byte_valid;
  assign m_axis_tlast  = out_res.string_done;

endmodule

// ----- hw/rtl/utf8lm_core.sv -----
// per-string state and single-pass byte logic: shape scan, counters, latin-1 recovery
// depends on utf8lm_pkg

module utf8lm_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  en,
  input  logic [7:0]                            in_byte,
  input  logic                                  is_last,
  input  logic [utf8lm_pkg::CFG_WIDTH-1:0]      min_latin1_count,
  output utf8lm_pkg::result_t                   result
);

  logic                  skip_remaining_lo, skip_remaining_hi;
  logic [1:0]            skip_remaining, skip_remaining_next;
  logic                  lead_pending, lead_pending_next;
  logic                  lead_high_bit, lead_high_bit_next;
  utf8lm_pkg::count_t    latin1_count, latin1_count_next;
  utf8lm_pkg::count_t    other_multibyte_count, other_multibyte_count_next;
  utf8lm_pkg::count_t    code_point_count, code_point_count_next;
  logic                  extract_failed, extract_failed_next;

  logic is2, is3, is4, latin_lead;
  logic valid;
  logic [7:0] rec;
  logic [utf8lm_pkg::CMP_WIDTH-1:0] latin_ext, min_ext, cp_ext, latin_dbl;

  assign skip_remaining = {skip_remaining_hi, skip_remaining_lo};

  always_comb begin
    is2 = (in_byte[7:5] == 3'b110);
    is3 = (in_byte[7:4] == 4'b1110);
    is4 = (in_byte[7:3] == 5'b11110);
    latin_lead = in_byte inside {utf8lm_pkg::LEAD_C2, utf8lm_pkg::LEAD_C3};

    // shape scan
    skip_remaining_next        = skip_remaining;
    latin1_count_next          = latin1_count;
    other_multibyte_count_next = other_multibyte_count;
    code_point_count_next      = code_point_count;
    if (skip_remaining != 2'd0) begin
      skip_remaining_next = skip_remaining - 2'd1;
    end else begin
      code_point_count_next = utf8lm_pkg::sat_inc(code_point_count);
      if (is2 && latin_lead) begin
        latin1_count_next = utf8lm_pkg::sat_inc(latin1_count);
      end else if (is2 || is3 || is4) begin
        other_multibyte_count_next = utf8lm_pkg::sat_inc(other_multibyte_count);
      end
      if (is2) begin
        skip_remaining_next = 2'd1;
      end else if (is3) begin
        skip_remaining_next = 2'd2;
      end else if (is4) begin
        skip_remaining_next = 2'd3;
      end else begin
        skip_remaining_next = 2'd0;
      end
    end

    // latin-1 recovery
    rec                 = 8'h00;
    valid               = 1'b0;
    lead_pending_next   = lead_pending;
    lead_high_bit_next  = lead_high_bit;
    extract_failed_next = extract_failed;
    if (lead_pending) begin
      lead_pending_next = 1'b0;
      if (in_byte[7:6] == 2'b10) begin
        rec   = {1'b1, lead_high_bit, in_byte[5:0]};
        valid = 1'b1;
      end else begin
        extract_failed_next = 1'b1;
      end
    end else if (!in_byte[7]) begin
      rec   = in_byte;
      valid = 1'b1;
    end else if (latin_lead && !is_last) begin
      lead_pending_next  = 1'b1;
      lead_high_bit_next = in_byte[0];
    end else begin
      extract_failed_next = 1'b1;
    end

    // end-of-string test on the updated counts
    latin_ext = utf8lm_pkg::CMP_WIDTH'(latin1_count_next);
    min_ext   = utf8lm_pkg::CMP_WIDTH'(min_latin1_count);
    cp_ext    = utf8lm_pkg::CMP_WIDTH'(code_point_count_next);
    latin_dbl = latin_ext << 1;

    result.recovered_byte = (valid && !extract_failed_next) ? rec : 8'h00;
    result.byte_valid     = valid && !extract_failed_next;
    result.string_done    = is_last;
    result.legacy_pattern = is_last && (other_multibyte_count_next == '0)
                            && (latin_ext >= min_ext) && (latin_dbl >= cp_ext);
    result.extraction_ok  = is_last && !extract_failed_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      skip_remaining_lo     <= 1'b0;
      skip_remaining_hi     <= 1'b0;
      lead_pending          <= 1'b0;
      lead_high_bit         <= 1'b0;
      latin1_count          <= '0;
      other_multibyte_count <= '0;
      code_point_count      <= '0;
      extract_failed        <= 1'b0;
    end else if (en) begin
      if (is_last) begin
        // string ends: drop any owed skip and clear everything
        skip_remaining_lo     <= 1'b0;
        skip_remaining_hi     <= 1'b0;
        lead_pending          <= 1'b0;
        lead_high_bit         <= 1'b0;
        latin1_count          <= '0;
        other_multibyte_count <= '0;
        code_point_count      <= '0;
        extract_failed        <= 1'b0;
      end else begin
        skip_remaining_lo     <= skip_remaining_next[0];
        skip_remaining_hi     <= skip_remaining_next[1];
        lead_pending          <= lead_pending_next;
        lead_high_bit         <= lead_high_bit_next;
        latin1_count          <= latin1_count_next;
        other_multibyte_count <= other_multibyte_count_next;
        code_point_count      <= code_point_count_next;
        extract_failed        <= extract_failed_next;
      end
    end
  end

endmodule

// ----- hw/rtl/utf8lm_checker.sv -----
// port-level checks for utf8_latin1_mojibake_detector, bound to the top level
// depends only on the top level's ports

module utf8lm_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // stalled transaction holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // end-of-string flags stay low mid-string
  a_flags_at_end: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[9:8] == 2'b00)
    else $error("end flags set before string end");

  // a byte with no recovery carries zero
  a_zero_when_invalid: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[7:0] == 8'h00)
    else $error("nonzero recovered byte without byte valid");

  // a recovered final byte means the string never failed
  a_valid_last_ok: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast && m_axis_tuser |-> m_axis_tdata[9])
    else $error("valid final byte but extraction failed");

endmodule

bind utf8_latin1_mojibake_detector utf8lm_checker u_utf8lm_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

// ----- tb/sv/tb_utf8_latin1_mojibake_detector.sv -----
// self-checking testbench for utf8_latin1_mojibake_detector: directed and random byte strings,
// a cycle-free predictor of the recovery and shape scan, random source gaps and sink stalls
// depends on utf8lm_pkg and the detector rtl

module tb_utf8_latin1_mojibake_detector;
  import utf8lm_pkg::*;

  localparam int RANDOM_ITEMS   = 1200;
  localparam int CFG_PHASE_LEN  = 300;
  localparam int REPORT_LIMIT   = 10;
  localparam int SETTLE_CYCLES  = 6;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;  // in_byte
  logic        s_axis_tlast  = 1'b0;  // is_last
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b1;
  logic [15:0] m_axis_tdata;  // recovered_byte, legacy_pattern, extraction_ok, zero fill
  logic        m_axis_tuser;  // byte_valid
  logic        m_axis_tlast;  // string_done
  logic        cfg_we    = 1'b0;
  logic [CFG_WIDTH-1:0] cfg_wdata = '0;

  utf8_latin1_mojibake_detector dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state, mirrors the block's per-string state
  logic [CFG_WIDTH-1:0] min_latin1 = MIN_LATIN1_RESET;
  logic [1:0] scan_skip       = '0;
  logic       lead_wait       = 1'b0;
  logic       lead_bit        = 1'b0;
  logic       recovery_failed = 1'b0;
  count_t     latin1_seen     = '0;
  count_t     other_seen      = '0;
  count_t     code_points     = '0;

  result_t    predicted_results[$];
  logic [7:0] text_q[$];
  int unsigned mismatch_count = 0;

  // idling controls
  bit          gaps_on  = 1'b1;
  bit          stall_on = 1'b1;
  int unsigned burst_left = 0;
  logic [15:0] stall_pattern = 16'hA5C3;
  logic [3:0]  stall_pos = '0;

  result_t got_result;
  result_t want_result;

  // append one byte to the string under construction
  task automatic add_text(input logic [7:0] b);
    text_q.insert(text_q.size(), b);
  endtask

  // work out the result of one accepted byte and queue it
  task automatic recover_byte(input logic [7:0] b, input logic last);
    result_t     r;
    int unsigned seq_len;
    r = '0;
    if (scan_skip != 0) begin
      scan_skip--;
    end else begin
      seq_len = 1;
      if (b[7:5] == 3'b110) seq_len = 2;
      else if (b[7:4] == 4'b1110) seq_len = 3;
      else if (b[7:3] == 5'b11110) seq_len = 4;
      if (code_points != '1) code_points++;
      if (seq_len == 2 && (b == LEAD_C2 || b == LEAD_C3)) begin
        if (latin1_seen != '1) latin1_seen++;
      end else if (seq_len > 1) begin
        if (other_seen != '1) other_seen++;
      end
      scan_skip = 2'(seq_len - 1);
    end

    if (lead_wait) begin
      lead_wait = 1'b0;
      if (b[7:6] == 2'b10) begin
        r.recovered_byte = {1'b1, lead_bit, b[5:0]};
        r.byte_valid     = 1'b1;
      end else begin
        recovery_failed = 1'b1;
      end
    end else if (!b[7]) begin
      r.recovered_byte = b;
      r.byte_valid     = 1'b1;
    end else if ((b == LEAD_C2 || b == LEAD_C3) && !last) begin
      lead_wait = 1'b1;
      lead_bit  = b[0];
    end else begin
      recovery_failed = 1'b1;
    end

    // sticky failure masks every later byte of the string
    if (recovery_failed) begin
      r.byte_valid     = 1'b0;
      r.recovered_byte = '0;
    end

    r.string_done = last;
    if (last) begin
      // doubled count needs one extra bit so saturated values still compare right
      r.legacy_pattern = (other_seen == '0) && (latin1_seen >= min_latin1) &&
                         ({1'b0, latin1_seen, 1'b0} >= {2'b00, code_points});
      r.extraction_ok  = !recovery_failed;
      scan_skip       = '0;
      lead_wait       = 1'b0;
      lead_bit        = 1'b0;
      recovery_failed = 1'b0;
      latin1_seen     = '0;
      other_seen      = '0;
      code_points     = '0;
    end
    predicted_results.insert(predicted_results.size(), r);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    if (gaps_on && burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 16);
    end
    if (burst_left > 0) burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    recover_byte(b, last);
  endtask

  task automatic send_text();
    foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1);
  endtask

  // stop the source until every queued result has come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (predicted_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_min_latin1(input logic [CFG_WIDTH-1:0] value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    min_latin1 = value;
  endtask

  function automatic string fmt_result(input result_t r);
    return $sformatf("byte=%02h valid=%0b done=%0b legacy=%0b ok=%0b",
                     r.recovered_byte, r.byte_valid, r.string_done,
                     r.legacy_pattern, r.extraction_ok);
  endfunction

  task automatic note_mismatch(input string what, input result_t want, input result_t got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT)
      $display("%s: want %s, got %s", what, fmt_result(want), fmt_result(got));
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got_result.recovered_byte = m_axis_tdata[7:0];
      got_result.legacy_pattern = m_axis_tdata[8];
      got_result.extraction_ok  = m_axis_tdata[9];
      got_result.byte_valid     = m_axis_tuser;
      got_result.string_done    = m_axis_tlast;
      if (predicted_results.size() == 0) begin
        note_mismatch("unexpected transaction", '0, got_result);
      end else begin
        want_result = predicted_results.pop_front();
        if (got_result.recovered_byte !== want_result.recovered_byte ||
            got_result.byte_valid     !== want_result.byte_valid     ||
            got_result.string_done    !== want_result.string_done    ||
            got_result.legacy_pattern !== want_result.legacy_pattern ||
            got_result.extraction_ok  !== want_result.extraction_ok)
          note_mismatch("result mismatch", want_result, got_result);
      end
    end
  end

  // sink stalls follow a rotating 16-bit pattern, reloaded now and then
  always @(posedge clk) begin
    if (!stall_on) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= stall_pattern[stall_pos];
      stall_pos     <= stall_pos + 4'd1;
      if (stall_pos == 4'hF && $urandom_range(0, 3) == 0)
        stall_pattern <= 16'($urandom) | 16'h0001;
    end
  end

  task automatic test_ascii_extremes();
    text_q = '{8'h00, 8'h7F};
    send_text();
    text_q = '{8'h41};
    send_text();
  endtask

  // three pairs at the reset threshold of three
  task automatic test_latin1_pairs();
    text_q = '{LEAD_C2, 8'h80, LEAD_C3, 8'hBF, 8'h41, LEAD_C3, 8'h80};
    send_text();
  endtask

  // pending lead followed by a non-continuation, then failure stays sticky
  task automatic test_broken_lead();
    text_q = '{LEAD_C3, 8'h41, 8'h42};
    send_text();
  endtask

  task automatic test_dangling_lead();
    text_q = '{8'h41, LEAD_C2};
    send_text();
  endtask

  // 4-byte, 3-byte, 11111xxx, other 2-byte lead and a truncated 3-byte at the end
  task automatic test_other_multibyte();
    text_q = '{8'hF0, 8'h9F, 8'h98, 8'h80, 8'hE2, 8'h82, 8'hAC, 8'hF8, 8'hC4, 8'h80, 8'hE2};
    send_text();
  endtask

  task automatic test_min_latin1_extremes();
    write_min_latin1('0);
    text_q = '{8'h41};
    send_text();
    text_q = '{LEAD_C2, 8'hA0};
    send_text();
    write_min_latin1('1);
    text_q = '{LEAD_C2, 8'h80, LEAD_C3, 8'h81, LEAD_C2, 8'h82};
    send_text();
  endtask

  task automatic build_string();
    int unsigned flavor;
    int unsigned n_tokens;
    int unsigned pick;
    flavor   = $urandom_range(0, 19);
    n_tokens = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
    text_q.delete();
    repeat (n_tokens) begin
      pick = $urandom_range(0, 99);
      if (flavor >= 17) begin
        // noise and broken pairs
        if (pick < 50) begin
          add_text(8'($urandom));
        end else begin
          add_text(pick[0] ? LEAD_C3 : LEAD_C2);
          add_text(8'($urandom));
        end
      end else if (pick < 40) begin
        add_text(8'($urandom_range(0, 127)));
      end else if (flavor < 10 || pick < 75) begin
        add_text(pick[0] ? LEAD_C3 : LEAD_C2);
        add_text(8'h80 | 8'($urandom_range(0, 63)));
      end else if (pick < 85) begin
        add_text(8'hC0 | 8'($urandom_range(0, 31)));
        add_text(8'h80 | 8'($urandom_range(0, 63)));
      end else if (pick < 93) begin
        add_text(8'hE0 | 8'($urandom_range(0, 15)));
        repeat (2) add_text(8'h80 | 8'($urandom_range(0, 63)));
      end else begin
        add_text(8'hF0 | 8'($urandom_range(0, 7)));
        repeat (3) add_text(8'h80 | 8'($urandom_range(0, 63)));
      end
    end
  endtask

  task automatic test_random_strings();
    int unsigned sent;
    int unsigned next_cfg;
    int unsigned phase;
    logic [CFG_WIDTH-1:0] threshold;
    sent     = 0;
    next_cfg = CFG_PHASE_LEN;
    phase    = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent >= next_cfg) begin
        phase++;
        case ($urandom_range(0, 5))
          0:       threshold = '0;
          1:       threshold = '1;
          default: threshold = CFG_WIDTH'($urandom_range(1, 8));
        endcase
        write_min_latin1(threshold);
        // one phase runs with no idling on either side
        gaps_on  = (phase != 2) && ($urandom_range(0, 3) != 0);
        stall_on = (phase != 2) && ($urandom_range(0, 3) != 0);
        next_cfg += CFG_PHASE_LEN;
      end
      build_string();
      send_text();
      sent += text_q.size();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_ascii_extremes();
    test_latin1_pairs();
    test_broken_lead();
    test_dangling_lead();
    test_other_multibyte();
    test_min_latin1_extremes();
    test_random_strings();
    drain();
    if (predicted_results.size() != 0) mismatch_count++;
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/utf8lm_pkg.sv
hw/rtl/utf8lm_core.sv
hw/rtl/utf8_latin1_mojibake_detector.sv
hw/rtl/utf8lm_checker.sv
tb/sv/tb_utf8_latin1_mojibake_detector.sv
